>>> sv/token_classifier_stream_defines.svh
// Assertion macros shared by the token classifier stream RTL.
`ifndef TOKEN_CLASSIFIER_STREAM_DEFINES_SVH
`define TOKEN_CLASSIFIER_STREAM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcs assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcs assertion failed");

`endif

>>> sv/tcs_pkg.sv
// Types, codes and keyword tables for the token classifier stream.
package tcs_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    // Keyword list
    localparam int          KW_COUNT    = 20;
    localparam logic [4:0]  KW_NONE     = 5'd11;
    localparam logic [4:0]  KW_NO_MATCH = 5'd20;

    // Event kinds
    localparam logic [1:0] KIND_ECHO   = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Token classes
    localparam logic [2:0] CL_OPEN      = 3'd0;
    localparam logic [2:0] CL_CLOSE     = 3'd1;
    localparam logic [2:0] CL_INT       = 3'd2;
    localparam logic [2:0] CL_STRING    = 3'd3;
    localparam logic [2:0] CL_KEYWORD   = 3'd4;
    localparam logic [2:0] CL_NAME      = 3'd5;
    localparam logic [2:0] CL_END       = 3'd6;
    localparam logic [2:0] CL_UNDECIDED = 3'd7;

    // Special characters
    localparam logic [7:0] CH_OPEN       = 8'h28;
    localparam logic [7:0] CH_CLOSE      = 8'h29;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_MINUS      = 8'h2d;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_NEWLINE    = 8'h0a;
    localparam logic [7:0] CH_TAB        = 8'h09;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_STRING
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  character_out;
        logic [2:0]  token_class;
        logic [4:0]  keyword_number;
        logic        none_as_zero;
        logic [15:0] token_length;
        logic        last_of_run;
    } result_t;

    // Up to two results produced by one request
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

    typedef struct packed {
        scan_mode_t mode;
        logic       error_latched;
    } scan_status_t;

    function automatic logic [3:0] kw_len(input logic [4:0] idx);
        case (idx)
            5'd0:    kw_len = 4'd3;
            5'd1:    kw_len = 4'd2;
            5'd2:    kw_len = 4'd1;
            5'd3:    kw_len = 4'd1;
            5'd4:    kw_len = 4'd1;
            5'd5:    kw_len = 4'd1;
            5'd6:    kw_len = 4'd2;
            5'd7:    kw_len = 4'd2;
            5'd8:    kw_len = 4'd8;
            5'd9:    kw_len = 4'd6;
            5'd10:   kw_len = 4'd5;
            5'd11:   kw_len = 4'd4;
            5'd12:   kw_len = 4'd6;
            5'd13:   kw_len = 4'd2;
            5'd14:   kw_len = 4'd5;
            5'd15:   kw_len = 4'd3;
            5'd16:   kw_len = 4'd8;
            5'd17:   kw_len = 4'd8;
            5'd18:   kw_len = 4'd11;
            5'd19:   kw_len = 4'd7;
            default: kw_len = 4'd0;
        endcase
    endfunction

    // Keyword text, right aligned: last character in the low byte
    function automatic logic [127:0] kw_text(input logic [4:0] idx);
        case (idx)
            5'd0:    kw_text = 128'("and");
            5'd1:    kw_text = 128'("or");
            5'd2:    kw_text = 128'("+");
            5'd3:    kw_text = 128'("-");
            5'd4:    kw_text = 128'("*");
            5'd5:    kw_text = 128'("/");
            5'd6:    kw_text = 128'("lt");
            5'd7:    kw_text = 128'("eq");
            5'd8:    kw_text = 128'("function");
            5'd9:    kw_text = 128'("struct");
            5'd10:   kw_text = 128'("arrow");
            5'd11:   kw_text = 128'("None");
            5'd12:   kw_text = 128'("assign");
            5'd13:   kw_text = 128'("if");
            5'd14:   kw_text = 128'("while");
            5'd15:   kw_text = 128'("for");
            5'd16:   kw_text = 128'("sequence");
            5'd17:   kw_text = 128'("intprint");
            5'd18:   kw_text = 128'("stringprint");
            5'd19:   kw_text = 128'("readint");
            default: kw_text = '0;
        endcase
    endfunction

    // Character at position pos of keyword idx; only meaningful for pos < length
    function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [3:0] pos);
        logic [127:0] txt;
        logic [3:0]   sh;
        txt = kw_text(idx);
        sh = kw_len(idx) - 4'd1 - pos;
        kw_char = txt[{sh, 3'b000} +: 8];
    endfunction

endpackage

>>> sv/tcs_in_if.sv
// Request channel carrying source characters into the classifier.
interface tcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_input;

    modport source (output valid, output character, output end_of_input, input ready);
    modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

>>> sv/tcs_out_if.sv
// Result channel carrying echoes, finished tokens and errors.
interface tcs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [7:0]  character_out;
    logic [2:0]  token_class;
    logic [4:0]  keyword_number;
    logic        none_as_zero;
    logic [15:0] token_length;
    logic        last_of_run;

    modport source (
        output valid, output event_kind, output character_out, output token_class,
        output keyword_number, output none_as_zero, output token_length,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input event_kind, input character_out, input token_class,
        input keyword_number, input none_as_zero, input token_length,
        input last_of_run, output ready
    );
endinterface

>>> sv/tcs_scanner.sv
// Token scanner: state of the current token and the results of one request.
module tcs_scanner #(
    parameter int LENGTH_BITS = tcs_pkg::LENGTH_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  tcs_pkg::item_t        item,
    output tcs_pkg::result_pair_t pair,
    output tcs_pkg::scan_status_t status
);
    import tcs_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    scan_mode_t             mode_reg, mode_next;
    logic [2:0]             class_reg, class_next;
    logic [LENGTH_BITS-1:0] chars_reg, chars_next;
    logic [KW_COUNT-1:0]    match_reg, match_next;
    logic                   minus_reg, minus_next;
    logic                   error_reg, error_next;

    logic [7:0]             c;
    logic                   eoi;
    logic                   is_digit, is_alpha, is_space, is_paren;
    logic [LENGTH_BITS-1:0] chars_take;
    logic [KW_COUNT-1:0]    match_take;
    logic [LENGTH_BITS-1:0] fin_chars;
    logic [LENGTH_BITS+15:0] fin_wide;
    logic [4:0]             fin_kw;
    logic                   fin_hit;
    result_t                echo_res, fin_res, paren_res, end_res, err_res;
    result_pair_t           pair_c;

    assign c   = item.character;
    assign eoi = item.end_of_input;

    // Character classes
    always_comb
    begin
        is_digit = c inside {[8'h30:8'h39]};
        is_alpha = c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
        is_space = c inside {CH_SPACE, CH_NEWLINE, CH_TAB};
        is_paren = c inside {CH_OPEN, CH_CLOSE};
    end

    // Count and keyword prefix match after taking this character
    always_comb
    begin
        chars_take = (chars_reg == LEN_MAX) ? chars_reg : chars_reg + LENGTH_BITS'(1);
        for (int i = 0; i < KW_COUNT; i++)
        begin
            match_take[i] = match_reg[i]
                && (chars_reg < LENGTH_BITS'(kw_len(5'(i))))
                && (kw_char(5'(i), chars_reg[3:0]) == c);
        end
    end

    // Finished token: a string closes on its own quote, which is counted;
    // an end mark closes it without adding a character
    always_comb
    begin
        fin_chars = (mode_reg == MODE_STRING && !eoi) ? chars_take : chars_reg;
        fin_wide  = {16'b0, fin_chars};
        fin_kw  = KW_NO_MATCH;
        fin_hit = 1'b0;
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            if (match_reg[i] && (fin_chars == LENGTH_BITS'(kw_len(5'(i)))))
            begin
                fin_kw  = 5'(i);
                fin_hit = 1'b1;
            end
        end

        fin_res = '0;
        fin_res.event_kind   = KIND_FINISH;
        fin_res.token_length = (|fin_wide[LENGTH_BITS+15:16]) ? 16'hffff : fin_wide[15:0];
        fin_res.token_class  = class_reg;
        fin_res.keyword_number = KW_NO_MATCH;
        if (class_reg == CL_UNDECIDED)
        begin
            if (fin_hit && fin_kw == KW_NONE)
            begin
                fin_res.token_class  = CL_INT;
                fin_res.none_as_zero = 1'b1;
            end
            else if (fin_hit)
            begin
                fin_res.token_class    = CL_KEYWORD;
                fin_res.keyword_number = fin_kw;
            end
            else
            begin
                fin_res.token_class = CL_NAME;
            end
        end
        else if (class_reg == CL_KEYWORD)
        begin
            fin_res.keyword_number = fin_kw;
        end
    end

    // Fixed result shapes
    always_comb
    begin
        echo_res = '0;
        echo_res.event_kind    = KIND_ECHO;
        echo_res.character_out = c;

        paren_res = '0;
        paren_res.event_kind     = KIND_FINISH;
        paren_res.character_out  = c;
        paren_res.token_class    = (c == CH_OPEN) ? CL_OPEN : CL_CLOSE;
        paren_res.keyword_number = KW_NO_MATCH;
        paren_res.token_length   = 16'd1;

        end_res = '0;
        end_res.event_kind     = KIND_FINISH;
        end_res.token_class    = CL_END;
        end_res.keyword_number = KW_NO_MATCH;

        err_res = '0;
        err_res.event_kind    = KIND_ERROR;
        err_res.character_out = eoi ? 8'h00 : c;
    end

    // Main decision for one request
    always_comb
    begin
        mode_next  = mode_reg;
        class_next = class_reg;
        chars_next = chars_reg;
        match_next = match_reg;
        minus_next = minus_reg;
        error_next = error_reg;
        pair_c     = '0;

        if (error_reg)
        begin
            pair_c.count = 2'd1;
            pair_c.first = err_res;
        end
        else if (eoi)
        begin
            mode_next  = MODE_IDLE;
            class_next = CL_UNDECIDED;
            chars_next = '0;
            match_next = '1;
            minus_next = 1'b0;
            if (mode_reg != MODE_IDLE)
            begin
                pair_c.count  = 2'd2;
                pair_c.first  = fin_res;
                pair_c.second = end_res;
            end
            else
            begin
                pair_c.count = 2'd1;
                pair_c.first = end_res;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_STRING:
                begin
                    chars_next   = chars_take;
                    match_next   = match_take;
                    pair_c.first = echo_res;
                    pair_c.count = 2'd1;
                    if (c == CH_QUOTE)
                    begin
                        mode_next     = MODE_IDLE;
                        class_next    = CL_UNDECIDED;
                        chars_next    = '0;
                        match_next    = '1;
                        pair_c.second = fin_res;
                        pair_c.count  = 2'd2;
                    end
                end
                MODE_WORD:
                begin
                    if (is_space || is_paren)
                    begin
                        mode_next    = MODE_IDLE;
                        class_next   = CL_UNDECIDED;
                        chars_next   = '0;
                        match_next   = '1;
                        minus_next   = 1'b0;
                        pair_c.first = fin_res;
                        pair_c.count = 2'd1;
                        if (is_paren)
                        begin
                            pair_c.second = paren_res;
                            pair_c.count  = 2'd2;
                        end
                    end
                    else if (!minus_reg && class_reg == CL_INT && !is_digit)
                    begin
                        // malformed integer: sticky until reset
                        mode_next    = MODE_IDLE;
                        class_next   = CL_UNDECIDED;
                        chars_next   = '0;
                        match_next   = '1;
                        error_next   = 1'b1;
                        pair_c.first = err_res;
                        pair_c.count = 2'd1;
                    end
                    else
                    begin
                        if (minus_reg)
                        begin
                            minus_next = 1'b0;
                            if (is_digit)
                            begin
                                class_next = CL_INT;
                            end
                        end
                        else if (class_reg == CL_UNDECIDED
                                 && !(is_alpha || is_digit || c == CH_UNDERSCORE))
                        begin
                            class_next = CL_KEYWORD;
                        end
                        chars_next   = chars_take;
                        match_next   = match_take;
                        pair_c.first = echo_res;
                        pair_c.count = 2'd1;
                    end
                end
                default:
                begin
                    // idle: token state is already clear here
                    if (is_paren)
                    begin
                        pair_c.first = paren_res;
                        pair_c.count = 2'd1;
                    end
                    else if (!is_space)
                    begin
                        mode_next = MODE_WORD;
                        if (c == CH_QUOTE)
                        begin
                            mode_next  = MODE_STRING;
                            class_next = CL_STRING;
                        end
                        else if (is_digit)
                        begin
                            class_next = CL_INT;
                        end
                        else if (c == CH_MINUS)
                        begin
                            class_next = CL_KEYWORD;
                            minus_next = 1'b1;
                        end
                        else if (is_alpha)
                        begin
                            class_next = CL_UNDECIDED;
                        end
                        else
                        begin
                            class_next = CL_KEYWORD;
                        end
                        chars_next   = chars_take;
                        match_next   = match_take;
                        pair_c.first = echo_res;
                        pair_c.count = 2'd1;
                    end
                end
            endcase
        end

        pair_c.first.last_of_run  = (pair_c.count == 2'd1);
        pair_c.second.last_of_run = (pair_c.count == 2'd2);
    end

    // Token state, updated once per processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            class_reg <= CL_UNDECIDED;
            chars_reg <= '0;
            match_reg <= '1;
            minus_reg <= 1'b0;
            error_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            class_reg <= class_next;
            chars_reg <= chars_next;
            match_reg <= match_next;
            minus_reg <= minus_next;
            error_reg <= error_next;
        end
    end

    assign pair = pair_c;
    assign status.mode          = mode_reg;
    assign status.error_latched = error_reg;

endmodule

>>> sv/tcs_result_stage.sv
// Result register: holds up to two results and hands them out one at a time.
module tcs_result_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  tcs_pkg::result_pair_t pair,
    output logic                  can_load,
    tcs_out_if.source             result
);
    import tcs_pkg::*;

    logic [1:0] rem_reg, rem_next;
    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic       taken;

    assign taken    = result.valid && result.ready;
    assign can_load = (rem_reg == 2'd0) || (rem_reg == 2'd1 && taken);

    // Load a fresh pair, or move the second result up once the first goes
    always_comb
    begin
        rem_next  = rem_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (load)
        begin
            rem_next  = pair.count;
            head_next = pair.first;
            tail_next = pair.second;
        end
        else if (taken)
        begin
            rem_next  = rem_reg - 2'd1;
            head_next = tail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign result.valid          = (rem_reg != 2'd0);
    assign result.event_kind     = head_reg.event_kind;
    assign result.character_out  = head_reg.character_out;
    assign result.token_class    = head_reg.token_class;
    assign result.keyword_number = head_reg.keyword_number;
    assign result.none_as_zero   = head_reg.none_as_zero;
    assign result.token_length   = head_reg.token_length;
    assign result.last_of_run    = head_reg.last_of_run;

endmodule

>>> sv/token_classifier_stream.sv
// Streaming token classifier: top level with input register and assertions.
//
// feed carries one source byte per request, or an end-of-input mark.
// result carries echoes of token characters, finished tokens with their
// class, keyword index and length, and syntax errors; last_of_run marks
// the final result of each request. A request gives zero, one or two results.
// A request taken into the input register is classified into the result
// register once that register can load, and its first result is offered
// from the result register from then on.
// Throughput: one request per cycle while each gives at most one result
// and result is not stalled; a request that gives two results holds the
// result register for two output handshakes. Classification is a single
// pass per byte with all twenty keyword prefix matches updated in parallel.
// When result is stalled the input register still takes one request, then
// feed.ready drops until the result register frees up.
// Reset clears token state, the sticky error flag and both registers'
// valid state; no results are pending afterwards.
module token_classifier_stream #(
    parameter int LENGTH_BITS = tcs_pkg::LENGTH_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    tcs_in_if.sink  feed,
    tcs_out_if.source result
);
    import tcs_pkg::*;
    `include "token_classifier_stream_defines.svh"

    logic         in_vld_reg, in_vld_next;
    item_t        item_reg, item_next;
    logic         proc_fire;
    logic         can_load;
    logic         feed_take;
    result_pair_t pair;
    scan_status_t status;

    // Input register
    assign proc_fire  = in_vld_reg && can_load;
    assign feed.ready = !in_vld_reg || proc_fire;
    assign feed_take  = feed.valid && feed.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        item_next   = item_reg;
        if (feed_take)
        begin
            in_vld_next            = 1'b1;
            item_next.character    = feed.character;
            item_next.end_of_input = feed.end_of_input;
        end
        else if (proc_fire)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    // Classification
    tcs_scanner #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scanner (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (proc_fire),
        .item   (item_reg),
        .pair   (pair),
        .status (status)
    );

    // Output side
    tcs_result_stage u_result_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (proc_fire),
        .pair     (pair),
        .can_load (can_load),
        .result   (result)
    );

    // Checks
    `TCS_ASSERT_NEXT(a_error_sticky, clk, rst_n, status.error_latched, status.error_latched)
    `TCS_ASSERT_NOW(a_error_idle, clk, rst_n, status.error_latched, status.mode == MODE_IDLE)
    `TCS_ASSERT_NOW(a_stall_has_item, clk, rst_n, !feed.ready, in_vld_reg)
    `TCS_ASSERT_NOW(a_error_ends_run, clk, rst_n, result.valid && result.event_kind == KIND_ERROR, result.last_of_run)

endmodule
